FILE: rtl/announce_node_table_lru_core_macros.svh
// assertion macros shared by the announce node table rtl
`ifndef ANNOUNCE_NODE_TABLE_LRU_CORE_MACROS_SVH
`define ANNOUNCE_NODE_TABLE_LRU_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define ANTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("antl assertion failed");
// next-cycle implication, disabled while in reset
`define ANTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("antl assertion failed");
`else
`define ANTL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ANTL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/antl_pkg.sv
// types, constants and helpers for the announce node table
`timescale 1ns / 1ps
package antl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int KEY_W = 64;
  localparam int TIME_W = 31;
  localparam int SEEN_W = 32;
  localparam int HOPS_W = 8;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] first_heard;
    logic [TIME_W-1:0] last_heard;
    logic [SEEN_W-1:0] seen_count;
    logic [HOPS_W-1:0] hops;
  } entry_t;

  // update kind broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_HIT    = 2'd1,
    OP_APPEND = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  // command broadcast along the row
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  victim;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] now;
    logic [HOPS_W-1:0] hops;
  } cmd_t;

  // oldest-entry token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] tm;
    logic [IDX_W-1:0]  idx;
  } tok_t;

  // saturating announce count increment
  function automatic logic [SEEN_W-1:0] sat_inc(input logic [SEEN_W-1:0] v);
    logic [SEEN_W-1:0] r;
    r = (v == {SEEN_W{1'b1}}) ? v : v + SEEN_W'(1);
    return r;
  endfunction

endpackage

FILE: rtl/announce_node_table_lru_core.sv
// announce node table: row of slot cells, lookup, oldest-entry eviction and result register
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  dest hash high/low, now seconds, hop count
//  out_     output     out_valid/out_ready  slot, hit, evicted, evicted slot, count, occupancy
//
//  a hit or an append goes from transfer to result through the steps accept, lookup, commit
//  a miss on a full table adds a scan step while the oldest-entry token walks the row
//  one item at a time; the next transfer is taken once the previous one has committed
//  commit waits while a result is still held in the output register
//  reset clears the fill count and control; slot contents are undefined until written
`timescale 1ns / 1ps
`include "announce_node_table_lru_core_macros.svh"
module announce_node_table_lru_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_dest_hash_high,
  input  logic [63:0] in_dest_hash_low,
  input  logic [30:0] in_now_seconds,
  input  logic [7:0]  in_hop_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_slot,
  output logic        out_hit,
  output logic        out_evicted,
  output logic [5:0]  out_evicted_slot,
  output logic [31:0] out_times_seen,
  output logic [6:0]  out_occupancy
);

  localparam int N = antl_pkg::MAX_ENTRIES;
  localparam int IW = antl_pkg::IDX_W;
  localparam int CW = antl_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [antl_pkg::KEY_W-1:0]  key_high_r, key_low_r;
  logic [antl_pkg::TIME_W-1:0] now_r;
  logic [antl_pkg::HOPS_W-1:0] hops_r;
  logic [CW-1:0]               count_r;
  logic                        hit_r, full_r;
  logic [IW-1:0]               hit_slot_r, victim_r;
  logic [antl_pkg::SEEN_W-1:0] hit_cnt_r;

  logic                        out_valid_r;
  logic [5:0]                  slot_r, evicted_slot_r;
  logic                        out_hit_r, evicted_r;
  logic [31:0]                 times_r;
  logic [6:0]                  occ_r;

  antl_pkg::cmd_t              cmd;
  antl_pkg::entry_t            ent [N];
  antl_pkg::tok_t              tok [N+1];
  logic [N-1:0]                match;
  logic [antl_pkg::SEEN_W-1:0] cnt_part [N];
  logic [IW-1:0]               idx_part [N];
  logic [antl_pkg::SEEN_W-1:0] any_cnt;
  logic [IW-1:0]               any_idx;
  logic                        hit_any, full_now;
  logic                        in_xfer, commit_fire;
  logic [IW-1:0]               new_slot;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign commit_fire = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign full_now = (count_r == CW'(N));
  assign hit_any = |match;
  assign new_slot = full_r ? IW'(N - 1) : IW'(count_r);

  // broadcast command to the row
  always_comb begin
    cmd.op = antl_pkg::OP_HOLD;
    if (commit_fire) begin
      if (hit_r) begin
        cmd.op = antl_pkg::OP_HIT;
      end else if (full_r) begin
        cmd.op = antl_pkg::OP_EVICT;
      end else begin
        cmd.op = antl_pkg::OP_APPEND;
      end
    end
    cmd.slot = hit_r ? hit_slot_r : new_slot;
    cmd.victim = victim_r;
    cmd.key_high = key_high_r;
    cmd.key_low = key_low_r;
    cmd.now = now_r;
    cmd.hops = hops_r;
  end

  // oldest-entry token enters at slot zero on a miss with a full table
  always_comb begin
    tok[0].valid = (state_r == S_LOOK) && !hit_any && full_now;
    tok[0].tm = '0;
    tok[0].idx = '0;
  end

  // row of slot cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    antl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IW'(i)),
      .cmd       (cmd),
      .count_i   (count_r),
      .next_i    (ent[(i + 1 < N) ? i + 1 : i]),
      .tok_i     (tok[i]),
      .entry_o   (ent[i]),
      .tok_o     (tok[i+1]),
      .match_o   (match[i]),
      .hit_cnt_o (cnt_part[i]),
      .hit_idx_o (idx_part[i])
    );
  end

  // keys are unique, so the matching cell's fields can be or-ed together
  always_comb begin
    any_cnt = '0;
    any_idx = '0;
    for (int i = 0; i < N; i++) begin
      any_cnt = any_cnt | cnt_part[i];
      any_idx = any_idx | idx_part[i];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = (!hit_any && full_now) ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        if (tok[N].valid) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // captured item and lookup results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_high_r <= in_dest_hash_high;
      key_low_r <= in_dest_hash_low;
      now_r <= in_now_seconds;
      hops_r <= in_hop_count;
    end
    if (state_r == S_LOOK) begin
      hit_r <= hit_any;
      full_r <= full_now;
      hit_slot_r <= any_idx;
      hit_cnt_r <= any_cnt;
      victim_r <= '0;
    end
    if ((state_r == S_SCAN) && tok[N].valid) begin
      victim_r <= tok[N].idx;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit_fire && !hit_r && !full_r) begin
      count_r <= count_r + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      slot_r <= hit_r ? 6'(hit_slot_r) : 6'(new_slot);
      out_hit_r <= hit_r;
      evicted_r <= !hit_r && full_r;
      evicted_slot_r <= (!hit_r && full_r) ? 6'(victim_r) : 6'd0;
      times_r <= hit_r ? antl_pkg::sat_inc(hit_cnt_r) : 32'd1;
      occ_r <= (hit_r || full_r) ? 7'(count_r) : 7'(count_r + CW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot = slot_r;
  assign out_hit = out_hit_r;
  assign out_evicted = evicted_r;
  assign out_evicted_slot = evicted_slot_r;
  assign out_times_seen = times_r;
  assign out_occupancy = occ_r;

  // the fill count never passes the table size
  `ANTL_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(N))
  // the walk for the oldest entry only runs on a miss with a full table
  `ANTL_ASSERT_IMP(a_scan_full, clk, rst_n, state_r == S_SCAN, full_r && !hit_r)
  // an append grows the fill count by one
  `ANTL_ASSERT_NXT(a_append_grow, clk, rst_n, commit_fire && !hit_r && !full_r,
                   count_r == $past(count_r) + CW'(1))
  // a commit always leaves a result behind
  `ANTL_ASSERT_NXT(a_commit_out, clk, rst_n, commit_fire, out_valid_r)

endmodule

FILE: rtl/antl_cell.sv
// one table slot: key compare, update, shift and oldest-entry token stage
`timescale 1ns / 1ps
`include "announce_node_table_lru_core_macros.svh"
module antl_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [antl_pkg::IDX_W-1:0]   cell_idx,
  input  antl_pkg::cmd_t               cmd,
  input  logic [antl_pkg::CNT_W-1:0]   count_i,
  input  antl_pkg::entry_t             next_i,
  input  antl_pkg::tok_t               tok_i,
  output antl_pkg::entry_t             entry_o,
  output antl_pkg::tok_t               tok_o,
  output logic                         match_o,
  output logic [antl_pkg::SEEN_W-1:0]  hit_cnt_o,
  output logic [antl_pkg::IDX_W-1:0]   hit_idx_o
);

  antl_pkg::entry_t entry_r;
  antl_pkg::entry_t entry_nxt;
  antl_pkg::tok_t   tok_r;
  antl_pkg::tok_t   tok_nxt;
  logic             live;

  // slot holds a written entry only below the fill count
  assign live = ({1'b0, cell_idx} < count_i);
  assign match_o = live && (entry_r.key_high == cmd.key_high) &&
                   (entry_r.key_low == cmd.key_low);
  assign hit_cnt_o = match_o ? entry_r.seen_count : '0;
  assign hit_idx_o = match_o ? cell_idx : '0;
  assign entry_o = entry_r;
  assign tok_o = tok_r;

  // entry update
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      antl_pkg::OP_HIT: begin
        if (cell_idx == cmd.slot) begin
          entry_nxt.seen_count = antl_pkg::sat_inc(entry_r.seen_count);
          entry_nxt.last_heard = cmd.now;
          entry_nxt.hops = cmd.hops;
        end
      end
      antl_pkg::OP_APPEND, antl_pkg::OP_EVICT: begin
        if (cell_idx == cmd.slot) begin
          entry_nxt.key_high = cmd.key_high;
          entry_nxt.key_low = cmd.key_low;
          entry_nxt.first_heard = cmd.now;
          entry_nxt.last_heard = cmd.now;
          entry_nxt.seen_count = antl_pkg::SEEN_W'(1);
          entry_nxt.hops = cmd.hops;
        end else if ((cmd.op == antl_pkg::OP_EVICT) && (cell_idx >= cmd.victim)) begin
          entry_nxt = next_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // oldest-entry token: slot zero always takes it; later slots keep the incoming one unless strictly older
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && ((cell_idx == '0) || (entry_r.last_heard < tok_i.tm))) begin
      tok_nxt.tm = entry_r.last_heard;
      tok_nxt.idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.tm <= tok_nxt.tm;
    tok_r.idx <= tok_nxt.idx;
  end

  // a token leaving this cell never names a later slot
  `ANTL_ASSERT_IMP(a_tok_idx, clk, rst_n, tok_r.valid, tok_r.idx <= cell_idx)
  // the token advances exactly one cell per cycle
  `ANTL_ASSERT_NXT(a_tok_step, clk, rst_n, tok_i.valid, tok_r.valid)
  // the evicted slot never lies past the append slot
  `ANTL_ASSERT_IMP(a_evict_shift, clk, rst_n,
                   (cmd.op == antl_pkg::OP_EVICT), cmd.victim <= cmd.slot)

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the announce node table with oldest-entry eviction
`timescale 1ns / 1ps
module testbench;

  // one heard announce
  typedef struct packed {
    logic [63:0] hash_high;
    logic [63:0] hash_low;
    logic [30:0] now;
    logic [7:0]  hops;
  } announce_t;

  // one table result
  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        evicted;
    logic [5:0]  evicted_slot;
    logic [31:0] times_seen;
    logic [6:0]  occupancy;
  } table_result_t;

  // how the announce time moves within a stretch of random traffic
  typedef enum int {
    TIME_STEP,
    TIME_TIE,
    TIME_SCATTER
  } clock_mode_t;

  localparam int RANDOM_ITEMS = 1040;
  localparam int DRAIN_CYCLES = 100;
  localparam int KEY_POOL_MAX = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_dest_hash_high = '0;
  logic [63:0] in_dest_hash_low = '0;
  logic [30:0] in_now_seconds = '0;
  logic [7:0]  in_hop_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_slot;
  logic        out_hit;
  logic        out_evicted;
  logic [5:0]  out_evicted_slot;
  logic [31:0] out_times_seen;
  logic [6:0]  out_occupancy;

  announce_node_table_lru_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_dest_hash_high(in_dest_hash_high),
    .in_dest_hash_low (in_dest_hash_low),
    .in_now_seconds   (in_now_seconds),
    .in_hop_count     (in_hop_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot         (out_slot),
    .out_hit          (out_hit),
    .out_evicted      (out_evicted),
    .out_evicted_slot (out_evicted_slot),
    .out_times_seen   (out_times_seen),
    .out_occupancy    (out_occupancy)
  );

  // predicted table contents
  antl_pkg::entry_t node_table [antl_pkg::MAX_ENTRIES];
  int            node_fill = 0;

  announce_t     announce_queue [$];
  table_result_t pending_results [$];
  announce_t     key_pool [$];
  announce_t     on_bus;
  int            total_items = 0;
  int            accepted_items = 0;
  int            mismatches = 0;
  int            in_gap = 0;
  int            out_stall = 0;
  logic          calm = 1'b0;

  // clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // lookup, update and eviction of the predicted table for one announce
  function automatic table_result_t table_update(input announce_t a);
    table_result_t r;
    int n;
    int found;
    int victim;
    r = '0;
    n = node_fill;
    found = -1;
    for (int i = 0; i < n; i++) begin
      if (found < 0 && node_table[i].key_high == a.hash_high &&
          node_table[i].key_low == a.hash_low)
        found = i;
    end
    if (found >= 0) begin
      if (node_table[found].seen_count != 32'hFFFF_FFFF)
        node_table[found].seen_count = node_table[found].seen_count + 32'd1;
      node_table[found].last_heard = a.now;
      node_table[found].hops = a.hops;
      r.hit = 1'b1;
      r.slot = 6'(found);
      r.times_seen = node_table[found].seen_count;
    end else begin
      // table full: drop the least recently seen, lowest index on ties
      if (n >= antl_pkg::MAX_ENTRIES) begin
        victim = 0;
        for (int i = 1; i < n; i++) begin
          if (node_table[i].last_heard < node_table[victim].last_heard)
            victim = i;
        end
        for (int i = victim; i + 1 < n; i++)
          node_table[i] = node_table[i + 1];
        n = n - 1;
        r.evicted = 1'b1;
        r.evicted_slot = 6'(victim);
      end
      node_table[n].key_high = a.hash_high;
      node_table[n].key_low = a.hash_low;
      node_table[n].first_heard = a.now;
      node_table[n].last_heard = a.now;
      node_table[n].seen_count = 32'd1;
      node_table[n].hops = a.hops;
      r.slot = 6'(n);
      r.times_seen = 32'd1;
      n = n + 1;
    end
    node_fill = n;
    r.occupancy = 7'(n);
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_announce(input logic [63:0] hh, input logic [63:0] hl,
                              input logic [30:0] now, input logic [7:0] hops);
    announce_t a;
    a.hash_high = hh;
    a.hash_low = hl;
    a.now = now;
    a.hops = hops;
    announce_queue = {announce_queue, a};
    total_items++;
  endtask

  task automatic report(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  // stimulus: directed corners, then random traffic over a pool of known keys
  initial begin : stimulus
    logic [63:0] kh;
    logic [63:0] kl;
    logic [30:0] clock_s;
    logic [6:0]  flip;
    clock_mode_t mode;
    announce_t   k;
    int          pick;

    // extreme keys, times and hop counts
    add_announce(64'h0, 64'h0, 31'd0, 8'd0);
    add_announce('1, '1, 31'h7FFF_FFFF, 8'd128);
    add_announce({16{4'hA}}, {16{4'h5}}, 31'd1, 8'd1);
    add_announce({16{4'h5}}, {16{4'hA}}, 31'h4000_0000, 8'd127);
    // hits refresh time and hops and bump the count
    add_announce(64'h0, 64'h0, 31'd5, 8'd64);
    add_announce('1, '1, 31'd0, 8'd0);
    // keys that share one half with a stored key, then repeats of stored keys
    add_announce(64'h0, '1, 31'd7, 8'd3);
    add_announce('1, 64'h0, 31'd7, 8'd2);
    add_announce(64'h0, 64'h1, 31'd8, 8'd128);
    add_announce(64'h8000_0000_0000_0000, 64'h0, 31'd8, 8'd5);
    add_announce(64'h0, 64'h0, 31'd9, 8'd6);
    add_announce(64'h0, '1, 31'd9, 8'd7);
    add_announce({16{4'hA}}, {16{4'h5}}, 31'h7FFF_FFFF, 8'd128);

    clock_s = 31'($urandom_range(0, 1000));
    mode = TIME_STEP;
    for (int j = 0; j < RANDOM_ITEMS; j++) begin
      if (j % 40 == 0)
        mode = clock_mode_t'($urandom_range(0, 2));
      // key: repeat from the pool, near miss of a pool key, or fresh
      pick = $urandom_range(0, 99);
      if (pick < 45 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        kh = k.hash_high;
        kl = k.hash_low;
      end else begin
        if (pick < 53 && key_pool.size() > 0) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          flip = 7'($urandom_range(0, 127));
          kh = k.hash_high;
          kl = k.hash_low;
          if (flip[6]) kh[flip[5:0]] = ~kh[flip[5:0]];
          else kl[flip[5:0]] = ~kl[flip[5:0]];
        end else begin
          kh = {$urandom, $urandom};
          kl = {$urandom, $urandom};
        end
        k.hash_high = kh;
        k.hash_low = kl;
        key_pool = {key_pool, k};
        if (key_pool.size() > KEY_POOL_MAX)
          void'(key_pool.pop_front());
      end
      // time: small steps, long runs of equal times, or scattered values
      case (mode)
        TIME_STEP:    clock_s = clock_s + 31'($urandom_range(0, 3));
        TIME_TIE:     if ($urandom_range(0, 15) == 0) clock_s = clock_s + 31'd1;
        TIME_SCATTER: clock_s = 31'($urandom);
        default:      clock_s = clock_s + 31'd1;
      endcase
      add_announce(kh, kl, clock_s, 8'($urandom_range(0, 128)));
    end
  end

  // toggle between stretches without any idling and normal traffic
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // driver: one announce per transfer, random gaps between them
  always @(posedge clk) begin : driver
    int gap_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results = {pending_results, table_update(on_bus)};
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        gap_now = (in_valid && in_ready) ? pick_gap() : in_gap;
        if (gap_now == 0 && announce_queue.size() > 0) begin
          on_bus = announce_queue.pop_front();
          in_valid <= 1'b1;
          in_dest_hash_high <= on_bus.hash_high;
          in_dest_hash_low <= on_bus.hash_low;
          in_now_seconds <= on_bus.now;
          in_hop_count <= on_bus.hops;
          in_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          in_gap <= (gap_now > 0) ? gap_now - 1 : 0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : monitor
    table_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no announce pending, slot %0d", $time, out_slot);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_slot !== want.slot) report("slot", want.slot, out_slot);
          if (out_hit !== want.hit) report("hit", want.hit, out_hit);
          if (out_evicted !== want.evicted) report("evicted", want.evicted, out_evicted);
          if (out_evicted_slot !== want.evicted_slot)
            report("evicted_slot", want.evicted_slot, out_evicted_slot);
          if (out_times_seen !== want.times_seen)
            report("times_seen", want.times_seen, out_times_seen);
          if (out_occupancy !== want.occupancy)
            report("occupancy", want.occupancy, out_occupancy);
        end
      end
      // back-pressure of random length
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        out_stall <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // end of run once every announce is through and every result is in
  initial begin : finish_run
    wait (rst_n);
    while (accepted_items < total_items || pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/antl_pkg.sv
rtl/antl_cell.sv
rtl/announce_node_table_lru_core.sv
tb/testbench.sv
